// File: sv/rmst_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the range maximum segment tree.
// No dependencies; every other file of the block imports this package.
package rmst_pkg;

   localparam int VALUE_W = 32;
   localparam int POS_W   = 11;

   localparam logic ACT_SET   = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   typedef struct packed {
      logic               action;
      logic [POS_W-1:0]   position;
      logic [VALUE_W-1:0] new_value;
      logic [POS_W-1:0]   range_left;
      logic [POS_W-1:0]   range_right;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] range_max;
      logic               was_query;
   } rsp_type;

   typedef struct packed {
      logic    load;
      rsp_type result;
   } result_xfer_type;

endpackage

// File: sv/rmst_mem.sv
`timescale 1ns / 1ps
// Node memory of the segment tree: one write port and two registered read ports.
// Depends on rmst_pkg for the value width.
module rmst_mem import rmst_pkg::*; #(
   parameter int ADDR_W = 11
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [VALUE_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]  rd_addr_a,
   input  logic [ADDR_W-1:0]  rd_addr_b,
   output logic [VALUE_W-1:0] rd_data_a,
   output logic [VALUE_W-1:0] rd_data_b
);

   logic [VALUE_W-1:0] mem_ff [2**ADDR_W];
   logic [VALUE_W-1:0] rd_a_ff;
   logic [VALUE_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// File: sv/rmst_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the segment tree: clearing pass, leaf-to-root update walk and
// the bottom-up range query. Depends on rmst_pkg; drives the ports of rmst_mem.
module rmst_ctrl import rmst_pkg::*; #(
   parameter int LEAVES = 1024,
   parameter int ADDR_W = $clog2(LEAVES) + 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  req_type            req,
   input  logic               out_free,
   output logic               idle,
   output result_xfer_type    xfer,
   output logic               wr_en,
   output logic [ADDR_W-1:0]  wr_addr,
   output logic [VALUE_W-1:0] wr_data,
   output logic [ADDR_W-1:0]  rd_addr_a,
   output logic [ADDR_W-1:0]  rd_addr_b,
   input  logic [VALUE_W-1:0] rd_data_a,
   input  logic [VALUE_W-1:0] rd_data_b
);

   localparam int LOG   = ADDR_W - 1;
   localparam int SPAN  = 1 << LOG;
   localparam int IDX_W = ADDR_W + 1;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SET_LEAF,
      S_SET_UP,
      S_Q_ISSUE,
      S_Q_DRAIN,
      S_RESULT
   } state_type;

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic [ADDR_W-1:0]  node_ff, node_in;
   logic [VALUE_W-1:0] cur_ff, cur_in;
   logic [IDX_W-1:0]   lo_ff, lo_in;
   logic [IDX_W-1:0]   hi_ff, hi_in;
   logic               sel_a_ff, sel_a_in;
   logic               sel_b_ff, sel_b_in;
   logic [VALUE_W-1:0] pair_ff, pair_in;
   logic [VALUE_W-1:0] best_ff, best_in;
   logic               query_ff, query_in;

   logic [POS_W-1:0]   left_hi;
   logic [IDX_W-1:0]   right_c;
   logic               q_empty;
   logic               set_ok;
   logic [ADDR_W-1:0]  leaf;
   logic [ADDR_W-1:0]  parent;
   logic [VALUE_W-1:0] up_max;
   logic [VALUE_W-1:0] gated_a;
   logic [VALUE_W-1:0] gated_b;
   logic [IDX_W-1:0]   hi_m1;

   always_comb begin
      left_hi = (req.range_left == '0) ? POS_W'(1) : req.range_left;
      right_c = (32'(req.range_right) > 32'(LEAVES)) ? IDX_W'(LEAVES)
                                                      : IDX_W'(req.range_right);
      q_empty = 32'(left_hi) > 32'(right_c);
      set_ok  = (req.position != '0) && (32'(req.position) <= 32'(LEAVES));
      leaf    = ADDR_W'(SPAN) + ADDR_W'(req.position) - ADDR_W'(1);
      parent  = node_ff >> 1;
      up_max  = (rd_data_a > cur_ff) ? rd_data_a : cur_ff;
      gated_a = sel_a_ff ? rd_data_a : '0;
      gated_b = sel_b_ff ? rd_data_b : '0;
      hi_m1   = hi_ff - IDX_W'(1);
   end

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      node_in   = node_ff;
      cur_in    = cur_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      sel_a_in  = 1'b0;
      sel_b_in  = 1'b0;
      pair_in   = (gated_a > gated_b) ? gated_a : gated_b;
      best_in   = (pair_ff > best_ff) ? pair_ff : best_ff;
      query_in  = query_ff;
      wr_en     = 1'b0;
      wr_addr   = node_ff;
      wr_data   = cur_ff;
      rd_addr_a = lo_ff[ADDR_W-1:0];
      rd_addr_b = hi_m1[ADDR_W-1:0];

      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + ADDR_W'(1);
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               best_in  = '0;
               query_in = (req.action == ACT_QUERY);
               node_in  = leaf;
               cur_in   = req.new_value;
               lo_in    = IDX_W'(SPAN) + IDX_W'(left_hi) - IDX_W'(1);
               hi_in    = IDX_W'(SPAN) + right_c;
               if (req.action == ACT_QUERY) begin
                  state_in = q_empty ? S_RESULT : S_Q_ISSUE;
               end else begin
                  state_in = set_ok ? S_SET_LEAF : S_RESULT;
               end
            end
         end
         S_SET_LEAF: begin
            wr_en     = 1'b1;
            rd_addr_a = node_ff ^ ADDR_W'(1);
            state_in  = S_SET_UP;
         end
         S_SET_UP: begin
            wr_en     = 1'b1;
            wr_addr   = parent;
            wr_data   = up_max;
            rd_addr_a = parent ^ ADDR_W'(1);
            cur_in    = up_max;
            node_in   = parent;
            if (parent == ADDR_W'(1)) begin
               state_in = S_RESULT;
            end
         end
         S_Q_ISSUE: begin
            if (lo_ff < hi_ff) begin
               sel_a_in = lo_ff[0];
               sel_b_in = hi_ff[0];
               lo_in    = (lo_ff >> 1) + IDX_W'(lo_ff[0]);
               hi_in    = hi_ff >> 1;
            end else begin
               state_in = S_Q_DRAIN;
            end
         end
         S_Q_DRAIN: begin
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         sel_a_ff <= 1'b0;
         sel_b_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         sel_a_ff <= sel_a_in;
         sel_b_ff <= sel_b_in;
      end
      node_ff  <= node_in;
      cur_ff   <= cur_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      pair_ff  <= pair_in;
      best_ff  <= best_in;
      query_ff <= query_in;
   end

   assign idle                  = (state_ff == S_IDLE);
   assign xfer.load             = (state_ff == S_RESULT) && out_free;
   assign xfer.result.range_max = best_ff;
   assign xfer.result.was_query = query_ff;

endmodule

// File: sv/range_max_segment_tree_unit.sv
`timescale 1ns / 1ps
// Range maximum segment tree with point updates over LEAVES positions.
// The req_ channel takes a set or a query; one transfer is accepted when
// req_valid is high and req_stall is low. Each item gives exactly one rsp_
// transfer: the range maximum for a query, zero with was_query low for a set.
// The tree lives in one node memory of 2*SPAN words, SPAN being LEAVES rounded
// up to a power of two, with one write and two registered read ports.
// A set writes its leaf and then one ancestor per cycle, up to the root,
// before its result loads. A query reads two nodes per level, bottom up.
// A set out of range or an empty query goes straight to its result state.
// An item is worked on alone, so no new transfer is taken until the current
// item has loaded its result into the output register.
// After reset the block sweeps the memory to zero, one node a cycle, with
// req_stall held high throughout the sweep.
// A finished result sits in an output register; rsp_stall holds it there, and
// the next item is still taken while it waits, finishing into that register
// only once it is free.
module range_max_segment_tree_unit import rmst_pkg::*; #(
   parameter int LEAVES = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int ADDR_W = $clog2(LEAVES) + 1;

   logic               accept;
   logic               idle;
   logic               out_free;
   result_xfer_type    xfer;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic [ADDR_W-1:0]  rd_addr_a;
   logic [ADDR_W-1:0]  rd_addr_b;
   logic [VALUE_W-1:0] rd_data_a;
   logic [VALUE_W-1:0] rd_data_b;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   assign req_stall = !idle;
   assign accept    = req_valid && idle;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   rmst_ctrl #(
      .LEAVES (LEAVES),
      .ADDR_W (ADDR_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_data),
      .out_free  (out_free),
      .idle      (idle),
      .xfer      (xfer),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   rmst_mem #(
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (xfer.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (xfer.load) begin
         rsp_data_ff <= xfer.result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: tb/range_max_segment_tree_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for range_max_segment_tree_unit: directed sets and queries, then random traffic
// under changing idle and stall patterns, checked against a shadow max tree or typed row results.
// Depends on rmst_pkg and range_max_segment_tree_unit.
module range_max_segment_tree_unit_tb;
   import rmst_pkg::*;

   localparam int LEAVES = 1024;
   localparam int SPAN = 1 << $clog2(LEAVES);
   localparam int QUIET_LIMIT = 8000;
   localparam int PHASE_ITEMS = 220;

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } directed_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   logic [VALUE_W-1:0] shadow_nodes [0:2*SPAN-1];
   rsp_type            pending_results [$];
   directed_row_type   directed_rows [$];
   int                 send_idle_pct = 0;
   int                 stall_pct = 0;
   int                 error_count = 0;
   int                 results_seen = 0;
   int                 quiet_cycles = 0;
   int                 send_plan [4] = '{0, 62, 0, 29};
   int                 stall_plan [4] = '{0, 0, 62, 29};

   range_max_segment_tree_unit #(.LEAVES(LEAVES)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < stall_pct);
   end

   task automatic report_mismatch(input string what);
      if (error_count < 100)
         $display("mismatch at result %0d: %s", results_seen, what);
      error_count++;
   endtask

   function automatic void shadow_set_leaf(input int position, input logic [VALUE_W-1:0] value);
      int node;
      if (position < 1 || position > LEAVES)
         return;
      node = SPAN + position - 1;
      shadow_nodes[node] = value;
      while (node > 1) begin
         node = node / 2;
         shadow_nodes[node] = (shadow_nodes[2*node] > shadow_nodes[2*node+1]) ?
                              shadow_nodes[2*node] : shadow_nodes[2*node+1];
      end
   endfunction

   function automatic logic [VALUE_W-1:0] shadow_range_max(input int left, input int right);
      int                 lo;
      int                 hi;
      logic [VALUE_W-1:0] best;
      best = '0;
      if (left < 1)
         left = 1;
      if (right > LEAVES)
         right = LEAVES;
      if (left > right)
         return '0;
      lo = SPAN + left - 1;
      hi = SPAN + right;
      while (lo < hi) begin
         if (lo % 2 == 1) begin
            if (shadow_nodes[lo] > best)
               best = shadow_nodes[lo];
            lo++;
         end
         if (hi % 2 == 1) begin
            hi--;
            if (shadow_nodes[hi] > best)
               best = shadow_nodes[hi];
         end
         lo = lo / 2;
         hi = hi / 2;
      end
      return best;
   endfunction

   function automatic rsp_type predict_result(input req_type item);
      rsp_type r;
      if (item.action == ACT_SET) begin
         shadow_set_leaf(int'(item.position), item.new_value);
         r.range_max = '0;
         r.was_query = 1'b0;
      end else begin
         r.range_max = shadow_range_max(int'(item.range_left), int'(item.range_right));
         r.was_query = 1'b1;
      end
      return r;
   endfunction

   function automatic req_type random_request();
      req_type r;
      int      pick;
      int      a;
      int      b;
      r.action = ($urandom_range(0, 99) < 45) ? ACT_SET : ACT_QUERY;
      r.position = POS_W'($urandom);
      r.new_value = $urandom;
      r.range_left = POS_W'($urandom);
      r.range_right = POS_W'($urandom);
      pick = $urandom_range(0, 99);
      if (r.action == ACT_SET) begin
         if ($urandom_range(0, 9) != 0)
            r.position = POS_W'($urandom_range(1, LEAVES));
         else if ($urandom_range(0, 1) == 0)
            r.position = '0;
         else
            r.position = POS_W'($urandom_range(LEAVES + 1, 2047));
         if (pick >= 92)
            r.new_value = '1;
         else if (pick >= 80)
            r.new_value = '0;
         else if (pick >= 65)
            r.new_value = $urandom_range(0, 255);
      end else if (pick < 40) begin
         a = $urandom_range(1, LEAVES);
         b = a + $urandom_range(0, 15);
         r.range_left = POS_W'(a);
         r.range_right = POS_W'((b > LEAVES) ? LEAVES : b);
      end else if (pick < 70) begin
         a = $urandom_range(1, LEAVES);
         b = $urandom_range(1, LEAVES);
         r.range_left = POS_W'((a < b) ? a : b);
         r.range_right = POS_W'((a < b) ? b : a);
      end else if (pick < 80) begin
         r.range_left = POS_W'($urandom_range(0, 3));
         r.range_right = POS_W'($urandom_range(LEAVES - 3, 2047));
      end else if (pick < 90) begin
         a = $urandom_range(2, LEAVES);
         r.range_left = POS_W'(a);
         r.range_right = POS_W'($urandom_range(0, a - 1));
      end
      return r;
   endfunction

   task automatic add_row(input logic action, input int position, input logic [VALUE_W-1:0] value,
                          input int left, input int right, input bit typed,
                          input logic [VALUE_W-1:0] want_max);
      directed_row_type row;
      row.item.action = action;
      row.item.position = POS_W'(position);
      row.item.new_value = value;
      row.item.range_left = POS_W'(left);
      row.item.range_right = POS_W'(right);
      row.typed = typed;
      row.want.range_max = want_max;
      row.want.was_query = (action == ACT_QUERY);
      directed_rows.push_back(row);
   endtask

   task automatic send_item(input req_type item, input bit typed, input rsp_type typed_rsp);
      rsp_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      predicted = predict_result(item);
      pending_results.push_back(typed ? typed_rsp : predicted);
   endtask

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected transfer %h", rsp_data));
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.range_max !== want.range_max)
               report_mismatch($sformatf("range_max %h, want %h",
                                         rsp_data.range_max, want.range_max));
            if (rsp_data.was_query !== want.was_query)
               report_mismatch($sformatf("was_query %b, want %b",
                                         rsp_data.was_query, want.was_query));
         end
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("range_max_segment_tree_unit regression: fail");
         $finish;
      end
   end

   initial begin
      int phase;
      for (int n = 0; n < 2 * SPAN; n++)
         shadow_nodes[n] = '0;

      add_row(ACT_QUERY, 2047, 32'hA5A5_5A5A, 1, LEAVES, 1'b1, '0);
      add_row(ACT_QUERY, 0, 32'h5A5A_A5A5, 0, 2047, 1'b1, '0);
      add_row(ACT_SET, 1, 32'hFFFF_FFFF, 2047, 0, 1'b1, '0);
      add_row(ACT_SET, LEAVES, 32'h0000_0001, 0, 2047, 1'b1, '0);
      add_row(ACT_SET, 0, 32'hDEAD_BEEF, 5, 9, 1'b1, '0);
      add_row(ACT_SET, LEAVES + 1, 32'hAAAA_AAAA, 1, 1, 1'b1, '0);
      add_row(ACT_SET, 2047, 32'h5555_5555, 1, LEAVES, 1'b1, '0);
      add_row(ACT_QUERY, 0, 32'h0, 1, 1, 1'b0, '0);
      add_row(ACT_QUERY, 1, 32'hFFFF_FFFF, LEAVES, LEAVES, 1'b0, '0);
      add_row(ACT_QUERY, 2047, 32'h0, 2, LEAVES, 1'b0, '0);
      add_row(ACT_QUERY, 3, 32'h1234_5678, 5, 3, 1'b1, '0);
      add_row(ACT_QUERY, 2047, 32'hFFFF_FFFF, 2047, 0, 1'b1, '0);
      add_row(ACT_QUERY, 0, 32'h0, LEAVES + 1, 2047, 1'b1, '0);
      add_row(ACT_QUERY, 1, 32'h0, 0, 0, 1'b1, '0);
      add_row(ACT_SET, 512, 32'h7FFF_FFFF, 0, 0, 1'b1, '0);
      add_row(ACT_SET, 513, 32'h8000_0000, 2047, 2047, 1'b1, '0);
      add_row(ACT_QUERY, 0, 32'h0, 512, 513, 1'b0, '0);
      add_row(ACT_QUERY, 0, 32'h0, 2, LEAVES - 1, 1'b0, '0);
      add_row(ACT_QUERY, 0, 32'h0, 0, 512, 1'b0, '0);
      add_row(ACT_SET, 1, 32'h0000_0000, 2047, 2047, 1'b1, '0);
      add_row(ACT_QUERY, 2047, 32'hFFFF_FFFF, 1, LEAVES, 1'b0, '0);
      add_row(ACT_SET, LEAVES, 32'h0000_0000, 0, 0, 1'b1, '0);
      add_row(ACT_QUERY, 0, 32'h0, 1000, 2047, 1'b0, '0);
      add_row(ACT_QUERY, 0, 32'h0, 514, LEAVES, 1'b0, '0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

      for (phase = 0; phase < 8; phase++) begin
         send_idle_pct = send_plan[phase % 4];
         stall_pct = stall_plan[phase % 4];
         repeat (PHASE_ITEMS) send_item(random_request(), 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);

      if (error_count == 0)
         $display("range_max_segment_tree_unit regression: pass");
      else
         $display("range_max_segment_tree_unit regression: fail");
      $finish;
   end

endmodule

// File: filelist.f
sv/rmst_pkg.sv
sv/rmst_mem.sv
sv/rmst_ctrl.sv
sv/range_max_segment_tree_unit.sv
tb/range_max_segment_tree_unit_tb.sv
